// ----- rtl/dfir_pkg.sv -----
// ----------------------------------------------------------------------------
// dfir_pkg
// Shared constants, types and sizing helpers for the decimating FIR filter.
// ----------------------------------------------------------------------------
package dfir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int CIDX_W   = 6;
  localparam int OUT_W    = 37;

  localparam int DEF_TAPS        = 64;
  localparam int DEF_DECIMATION  = 4;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_COEF_BITS   = 16;

  // job queue between front and MAC
  localparam int Q_DEPTH = 2;

  // widest ring pointer / fill count over the supported parameter range
  localparam int JOB_PTR_W = 9;
  localparam int JOB_CNT_W = 9;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  typedef struct packed {
    logic [JOB_PTR_W-1:0] newest;
    logic [JOB_CNT_W-1:0] avail;
    logic                 last;
  } dfir_job_t;

  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic mac_busy;
  } dfir_fe_stat_t;

  function automatic int addr_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int cnt_w(input int n);
    return $clog2(n + 1);
  endfunction

  // sample ring holds the taps plus every sample that may land while jobs wait
  function automatic int ring_aw(input int taps, input int dec);
    return $clog2(taps + (Q_DEPTH + 1) * dec);
  endfunction

endpackage

// ----- rtl/dfir_if.sv -----
// ----------------------------------------------------------------------------
// dfir_if
// Valid/ready channels of the decimating FIR filter: input and result.
// ----------------------------------------------------------------------------
interface dfir_in_if;
  import dfir_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [SAMPLE_W-1:0] sample;
  logic                      sample_last;
  logic        [CIDX_W-1:0]  coef_index;
  logic signed [COEF_W-1:0]  coef_value;

  modport source (
    output valid, action, sample, sample_last, coef_index, coef_value,
    input  ready
  );

  modport sink (
    input  valid, action, sample, sample_last, coef_index, coef_value,
    output ready
  );
endinterface

interface dfir_out_if;
  import dfir_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered;
  logic                    result_last;

  modport source (
    output valid, filtered, result_last,
    input  ready
  );

  modport sink (
    input  valid, filtered, result_last,
    output ready
  );
endinterface

// ----- rtl/decimating_fir_filter_unit.sv -----
// ----------------------------------------------------------------------------
// decimating_fir_filter_unit
// Decimating FIR filter: coefficient/sample front, job queue, shared MAC.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   action, sample, sample_last, coef_index, coef_value
//  out_chan  out  valid/ready   filtered, result_last
//
//  Samples transfer one per cycle while the job queue has room.
//  Each result is computed in the single shared multiplier, with one sample
//  ring read and one coefficient read per tap.
//  Coefficient writes transfer only when the queue is empty and the MAC idle.
//  Reset is immediate: coefficient valid bits and a fill count stand in for
//  zeroed storage, so no clearing pass runs.
// ----------------------------------------------------------------------------
module decimating_fir_filter_unit #(
  parameter int TAPS        = dfir_pkg::DEF_TAPS,
  parameter int DECIMATION  = dfir_pkg::DEF_DECIMATION,
  parameter int SAMPLE_BITS = dfir_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS   = dfir_pkg::DEF_COEF_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  dfir_in_if.sink     in_chan,
  dfir_out_if.source  out_chan
);
  import dfir_pkg::*;

  localparam int RING_AW    = ring_aw(TAPS, DECIMATION);
  localparam int RING_DEPTH = 2 ** RING_AW;
  localparam int TAP_AW     = addr_w(TAPS);

  dfir_fe_stat_t stat;
  dfir_job_t     push_job, pop_job;
  logic          push, pop, q_full, q_empty, mac_busy;

  logic                   ring_we;
  logic [RING_AW-1:0]     ring_waddr, ring_raddr;
  logic [SAMPLE_BITS-1:0] ring_wdata, ring_rdata;
  logic                   coef_we;
  logic [TAP_AW-1:0]      coef_waddr, coef_raddr;
  logic [COEF_BITS-1:0]   coef_wdata, coef_rdata;
  logic [TAPS-1:0]        tap_vld;

  assign stat.q_full   = q_full;
  assign stat.q_empty  = q_empty;
  assign stat.mac_busy = mac_busy;

  dfir_front #(
    .TAPS        (TAPS),
    .DECIMATION  (DECIMATION),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .stat       (stat),
    .push       (push),
    .push_job   (push_job),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_wdata (ring_wdata),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .tap_vld    (tap_vld)
  );

  dfir_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  dfir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  dfir_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  dfir_mac #(
    .TAPS        (TAPS),
    .DECIMATION  (DECIMATION),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_vld    (~q_empty),
    .job        (pop_job),
    .pop        (pop),
    .tap_vld    (tap_vld),
    .ring_raddr (ring_raddr),
    .ring_rdata (ring_rdata),
    .coef_raddr (coef_raddr),
    .coef_rdata (coef_rdata),
    .mac_busy   (mac_busy),
    .out_chan   (out_chan)
  );

endmodule

// ----- rtl/dfir_ram.sv -----
// ----------------------------------------------------------------------------
// dfir_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [dfir_pkg::addr_w(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [dfir_pkg::addr_w(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]                    rdata
);
  import dfir_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rdata = rd_data_r;

endmodule

// ----- rtl/dfir_front.sv -----
// ----------------------------------------------------------------------------
// dfir_front
// Input side: coefficient writes, sample ring writes, group counting, job push.
// ----------------------------------------------------------------------------
module dfir_front #(
  parameter int TAPS        = 64,
  parameter int DECIMATION  = 4,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  dfir_in_if.sink                                            in_chan,
  input  dfir_pkg::dfir_fe_stat_t                            stat,
  output logic                                               push,
  output dfir_pkg::dfir_job_t                                push_job,
  output logic                                               ring_we,
  output logic [dfir_pkg::ring_aw(TAPS, DECIMATION)-1:0]     ring_waddr,
  output logic [SAMPLE_BITS-1:0]                             ring_wdata,
  output logic                                               coef_we,
  output logic [dfir_pkg::addr_w(TAPS)-1:0]                  coef_waddr,
  output logic [COEF_BITS-1:0]                               coef_wdata,
  output logic [TAPS-1:0]                                    tap_vld
);
  import dfir_pkg::*;

  localparam int RING_AW = ring_aw(TAPS, DECIMATION);
  localparam int TAP_AW  = addr_w(TAPS);
  localparam int CNT_W   = cnt_w(TAPS);
  localparam int PH_W    = addr_w(DECIMATION);

  logic [RING_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [PH_W-1:0]    phase_r, phase_nxt;
  logic [TAPS-1:0]    tap_vld_r, tap_vld_nxt;

  logic is_coef;
  logic xfer;
  logic smp_xfer;
  logic coef_xfer;
  logic coef_in_range;
  logic grp_done;

  assign is_coef       = (in_chan.action == ACT_COEF);
  // coefficient writes wait until no result is in flight
  assign in_chan.ready = is_coef ? (stat.q_empty & ~stat.mac_busy) : ~stat.q_full;
  assign xfer          = in_chan.valid & in_chan.ready;
  assign smp_xfer      = xfer & ~is_coef;
  assign coef_xfer     = xfer & is_coef;
  assign coef_in_range = (32'(in_chan.coef_index) < TAPS);
  assign grp_done      = (phase_r == PH_W'(DECIMATION - 1));

  always_comb begin
    wr_ptr_nxt  = wr_ptr_r;
    fill_nxt    = fill_r;
    phase_nxt   = phase_r;
    tap_vld_nxt = tap_vld_r;
    if (smp_xfer) begin
      wr_ptr_nxt = wr_ptr_r + RING_AW'(1);
      fill_nxt   = (fill_r == CNT_W'(TAPS)) ? fill_r : fill_r + CNT_W'(1);
      phase_nxt  = grp_done ? '0 : phase_r + PH_W'(1);
    end
    if (coef_we) begin
      tap_vld_nxt[coef_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      fill_r    <= '0;
      phase_r   <= '0;
      tap_vld_r <= '0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      fill_r    <= fill_nxt;
      phase_r   <= phase_nxt;
      tap_vld_r <= tap_vld_nxt;
    end
  end

  assign ring_we    = smp_xfer;
  assign ring_waddr = wr_ptr_nxt;
  assign ring_wdata = SAMPLE_BITS'($unsigned(in_chan.sample));

  assign coef_we    = coef_xfer & coef_in_range;
  assign coef_waddr = TAP_AW'(in_chan.coef_index);
  assign coef_wdata = COEF_BITS'($unsigned(in_chan.coef_value));

  assign tap_vld    = tap_vld_r;

  assign push            = smp_xfer & grp_done;
  assign push_job.newest = JOB_PTR_W'(wr_ptr_nxt);
  assign push_job.avail  = JOB_CNT_W'(fill_nxt);
  assign push_job.last   = in_chan.sample_last;

endmodule

// ----- rtl/dfir_jobq.sv -----
// ----------------------------------------------------------------------------
// dfir_jobq
// Short job queue between the front and the MAC.
// ----------------------------------------------------------------------------
module dfir_jobq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dfir_pkg::dfir_job_t push_job,
  input  logic                pop,
  output dfir_pkg::dfir_job_t pop_job,
  output logic                full,
  output logic                empty
);
  import dfir_pkg::*;

  localparam int QAW = addr_w(Q_DEPTH);
  localparam int QCW = cnt_w(Q_DEPTH);

  dfir_job_t        job_q_r [Q_DEPTH];
  logic [QAW-1:0]   head_r, tail_r;
  logic [QCW-1:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        tail_r <= (tail_r == QAW'(Q_DEPTH - 1)) ? '0 : tail_r + QAW'(1);
      end
      if (pop) begin
        head_r <= (head_r == QAW'(Q_DEPTH - 1)) ? '0 : head_r + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      job_q_r[tail_r] <= push_job;
    end
  end

  assign pop_job = job_q_r[head_r];
  assign full    = (count_r == QCW'(Q_DEPTH));
  assign empty   = (count_r == '0);

endmodule

// ----- rtl/dfir_mac.sv -----
// ----------------------------------------------------------------------------
// dfir_mac
// Back end: one shared multiply-accumulate walks the taps of a job, then
// clamps the sum into the result register.
// ----------------------------------------------------------------------------
module dfir_mac #(
  parameter int TAPS        = 64,
  parameter int DECIMATION  = 4,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           job_vld,
  input  dfir_pkg::dfir_job_t                            job,
  output logic                                           pop,
  input  logic [TAPS-1:0]                                tap_vld,
  output logic [dfir_pkg::ring_aw(TAPS, DECIMATION)-1:0] ring_raddr,
  input  logic [SAMPLE_BITS-1:0]                         ring_rdata,
  output logic [dfir_pkg::addr_w(TAPS)-1:0]              coef_raddr,
  input  logic [COEF_BITS-1:0]                           coef_rdata,
  output logic                                           mac_busy,
  dfir_out_if.source                                     out_chan
);
  import dfir_pkg::*;

  localparam int RING_AW  = ring_aw(TAPS, DECIMATION);
  localparam int TAP_AW   = addr_w(TAPS);
  localparam int CNT_W    = cnt_w(TAPS);
  localparam int PROD_W   = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_FULL = PROD_W + CNT_W + 1;
  localparam int SUM_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
  localparam int EXT_W    = (SUM_W > OUT_W) ? SUM_W : OUT_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } mac_state_t;

  mac_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [RING_AW-1:0] newest_r;
  logic [CNT_W-1:0]   avail_r;
  logic               last_r;

  logic p1_vld_r, p1_end_r, p1_use_r;
  logic p2_vld_r, p2_end_r;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0]  acc_r, acc_sum;
  logic signed [EXT_W-1:0]  acc_ext;
  logic [EXT_W-OUT_W:0]     hi_bits;
  logic [OUT_W-1:0]         sat;

  logic             out_vld_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_last_r;

  logic start, issue, last_iss, use_tap;

  assign start    = (state_r == ST_IDLE) & job_vld & (~out_vld_r | out_chan.ready);
  assign issue    = (state_r == ST_RUN);
  assign last_iss = (k_r == CNT_W'(TAPS - 1));
  assign use_tap  = (k_r < avail_r) & tap_vld[TAP_AW'(k_r)];
  assign pop      = start;
  assign mac_busy = (state_r != ST_IDLE);

  assign ring_raddr = newest_r - RING_AW'(k_r);
  assign coef_raddr = TAP_AW'(k_r);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        k_nxt = k_r + CNT_W'(1);
        if (last_iss) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (p2_end_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    prod_nxt = '0;
    if (p1_use_r) begin
      prod_nxt = $signed(ring_rdata) * $signed(coef_rdata);
    end
  end

  // sum wraps at SUM_W bits (at most 64), then clamps to the result range
  assign acc_sum = acc_r + SUM_W'(prod_r);
  assign acc_ext = EXT_W'(acc_sum);
  assign hi_bits = acc_ext[EXT_W-1:OUT_W-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      sat = acc_ext[OUT_W-1:0];
    end else if (acc_ext[EXT_W-1]) begin
      sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      k_r       <= '0;
      p1_vld_r  <= 1'b0;
      p1_end_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p2_end_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      p1_vld_r <= issue;
      p1_end_r <= issue & last_iss;
      p2_vld_r <= p1_vld_r;
      p2_end_r <= p1_end_r;
      if (p2_end_r) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      newest_r <= RING_AW'(job.newest);
      avail_r  <= CNT_W'(job.avail);
      last_r   <= job.last;
    end
    p1_use_r <= use_tap;
    prod_r   <= prod_nxt;
    if (start) begin
      acc_r <= '0;
    end else if (p2_vld_r) begin
      acc_r <= acc_sum;
    end
    if (p2_end_r) begin
      out_data_r <= sat;
      out_last_r <= last_r;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.filtered    = out_data_r;
  assign out_chan.result_last = out_last_r;

`ifndef SYNTH
  a_out_free_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_vld_r)
    else $error("result register occupied while a job runs");

  a_end_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    p2_end_r |-> (state_r == ST_DRAIN))
    else $error("final product outside drain");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r == ST_RUN) && (k_r == '0))
    else $error("job start did not begin at tap zero");
`endif

endmodule
